// File: hdl/dtsa_pkg.sv
// Package for the direction-to-spherical-angles block.
// Holds datapath widths, CORDIC constants, the arctangent table and angle helpers.
// No dependencies; every other file but dtsa_angles_if uses it.
package dtsa_pkg;

	localparam int COORD_WIDTH_DEF   = 32;
	localparam int CORDIC_STAGES_DEF = 20;

	// Normalized magnitudes keep their leading one at bit 32.
	localparam int NORM_W    = 33;
	localparam int GAIN_W    = 29;
	localparam int GAIN_FRAC = 28;
	localparam int YK_W      = NORM_W + GAIN_W - GAIN_FRAC;
	// CORDIC datapath: magnitudes grow to under 2^36 in the elevation chain.
	localparam int CW        = 38;
	localparam int ANG_W     = 16;
	localparam int QMAG_W    = 16;
	localparam int ANG_FRAC  = 8;
	localparam int DEG_W     = 9;

	localparam logic [GAIN_W-1:0] GAIN_Q28  = 29'd442048841;
	localparam logic [QMAG_W-1:0] DEG90_Q8  = 16'd23040;
	localparam logic [QMAG_W-1:0] DEG180_Q8 = 16'd46080;
	localparam logic [DEG_W-1:0]  FULL_TURN = 9'd360;

	typedef logic signed [CW-1:0]    cw_t;
	typedef logic signed [ANG_W-1:0] ang_t;
	typedef logic [QMAG_W-1:0]       qmag_t;
	typedef logic [DEG_W-1:0]        deg_t;

	// Per-item flags and carried values that ride along the pipeline.
	typedef struct packed {
		logic              neg_dx;
		logic              neg_dy;
		logic              neg_dz;
		logic              degen;
		logic              zero_x;
		logic              zero_y;
		logic              zero_z;
		logic [NORM_W-1:0] x0;
		logic [YK_W-1:0]   yk;
		deg_t              phi;
	} side_t;

	typedef struct packed {
		deg_t theta;
		deg_t phi;
		logic degen;
	} res_t;

	// atan(2^-i) in degrees, Q8, rounded.
	function automatic ang_t atan_q8(input int unsigned idx);
		case (idx)
			0:       return 16'sd11520;
			1:       return 16'sd6801;
			2:       return 16'sd3593;
			3:       return 16'sd1824;
			4:       return 16'sd916;
			5:       return 16'sd458;
			6:       return 16'sd229;
			7:       return 16'sd115;
			8:       return 16'sd57;
			9:       return 16'sd29;
			10:      return 16'sd14;
			11:      return 16'sd7;
			12:      return 16'sd4;
			13:      return 16'sd2;
			14:      return 16'sd1;
			default: return 16'sd0;
		endcase
	endfunction

	// Clamp a CORDIC base angle to 0..90 degrees.
	function automatic qmag_t clamp_q8(input ang_t a);
		if (a < 0)
			return '0;
		if (a > ang_t'(DEG90_Q8))
			return DEG90_Q8;
		return qmag_t'(a);
	endfunction

	// Truncate to whole degrees, wrap negative nonzero values by a full turn.
	function automatic deg_t to_deg(input qmag_t q, input logic neg);
		deg_t w;
		w = deg_t'(q >> ANG_FRAC);
		if (neg && (w != '0))
			return FULL_TURN - w;
		return w;
	endfunction

endpackage

// File: hdl/dtsa_points_if.sv
// Input channel interface: one start point and one end point per transaction.
// Depends on dtsa_pkg for the default coordinate width.
interface dtsa_points_if #(
	parameter int COORD_WIDTH = dtsa_pkg::COORD_WIDTH_DEF
);
	logic                          valid;
	logic                          ready;
	logic signed [COORD_WIDTH-1:0] start_x;
	logic signed [COORD_WIDTH-1:0] start_y;
	logic signed [COORD_WIDTH-1:0] start_z;
	logic signed [COORD_WIDTH-1:0] end_x;
	logic signed [COORD_WIDTH-1:0] end_y;
	logic signed [COORD_WIDTH-1:0] end_z;

	modport source (
		output valid, start_x, start_y, start_z, end_x, end_y, end_z,
		input  ready
	);
	modport sink (
		input  valid, start_x, start_y, start_z, end_x, end_y, end_z,
		output ready
	);
endinterface

// File: hdl/dtsa_angles_if.sv
// Output channel interface: elevation, azimuth and degenerate flag per transaction.
// Depends on nothing beyond the language.
interface dtsa_angles_if;
	logic       valid;
	logic       ready;
	logic [8:0] theta_deg;
	logic [8:0] phi_deg;
	logic       degenerate;

	modport source (
		output valid, theta_deg, phi_deg, degenerate,
		input  ready
	);
	modport sink (
		input  valid, theta_deg, phi_deg, degenerate,
		output ready
	);
endinterface

// File: hdl/dtsa_norm_cell.sv
// One step of the normalizing shifter: shift all three magnitudes left by SH
// when the top SH bits of their OR are clear. Depends on dtsa_pkg.
module dtsa_norm_cell #(
	parameter int AW = 33,
	parameter int SH = 1
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            advance,
	input  logic            valid,
	input  logic [AW-1:0]   mag_x,
	input  logic [AW-1:0]   mag_y,
	input  logic [AW-1:0]   mag_z,
	input  dtsa_pkg::side_t side,
	output logic            valid_q,
	output logic [AW-1:0]   mag_x_q,
	output logic [AW-1:0]   mag_y_q,
	output logic [AW-1:0]   mag_z_q,
	output dtsa_pkg::side_t side_q
);
	import dtsa_pkg::*;

	logic [AW-1:0] lead;
	logic          top_zero;

	assign lead     = mag_x | mag_y | mag_z;
	assign top_zero = (lead[AW-1 -: SH] == '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (advance) begin
			valid_q <= valid;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			mag_x_q <= top_zero ? (mag_x << SH) : mag_x;
			mag_y_q <= top_zero ? (mag_y << SH) : mag_y;
			mag_z_q <= top_zero ? (mag_z << SH) : mag_z;
			side_q  <= side;
		end
	end

endmodule

// File: hdl/dtsa_cordic_cell.sv
// One CORDIC vectoring micro-rotation with its output register.
// Depends on dtsa_pkg for datapath types and the arctangent table.
module dtsa_cordic_cell #(
	parameter int STAGE = 0
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            advance,
	input  logic            valid,
	input  dtsa_pkg::cw_t   x,
	input  dtsa_pkg::cw_t   y,
	input  dtsa_pkg::ang_t  a,
	input  dtsa_pkg::side_t side,
	output logic            valid_q,
	output dtsa_pkg::cw_t   x_q,
	output dtsa_pkg::cw_t   y_q,
	output dtsa_pkg::ang_t  a_q,
	output dtsa_pkg::side_t side_q
);
	import dtsa_pkg::*;

	localparam ang_t STEP = atan_q8(STAGE);

	cw_t  xs;
	cw_t  ys;
	cw_t  x_nx;
	cw_t  y_nx;
	ang_t a_nx;

	// Rotate toward the x axis; arithmetic shifts round toward minus infinity.
	always_comb begin
		xs = x >>> STAGE;
		ys = y >>> STAGE;
		if (!y[CW-1]) begin
			x_nx = x + ys;
			y_nx = y - xs;
			a_nx = a + STEP;
		end else begin
			x_nx = x - ys;
			y_nx = y + xs;
			a_nx = a - STEP;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (advance) begin
			valid_q <= valid;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			x_q    <= x_nx;
			y_q    <= y_nx;
			a_q    <= a_nx;
			side_q <= side;
		end
	end

endmodule

// File: hdl/direction_to_spherical_angles.sv
// Top level of the direction-to-spherical-angles converter.
// Depends on dtsa_pkg, dtsa_points_if, dtsa_angles_if, dtsa_norm_cell and dtsa_cordic_cell.
//
// Usage:
//   points carries one transaction per pair of points (start, end) in signed
//   fixed point; angles returns one transaction per input with the elevation
//   theta_deg, the azimuth phi_deg (both whole degrees, 0..359) and the
//   degenerate flag, in input order.
//   Throughput: one transaction per cycle, sustained while the skid entry is empty.
//   Path: registers for the differences, the magnitudes, the normalizing shifter
//   cells, the gain scaling, the azimuth chain, the azimuth result, the elevation
//   chain and the output register. Its length is set by the two CORDIC cell chains
//   (azimuth, then elevation on the azimuth magnitude) and the log-depth shifter.
//   Stall: the result register is backed by a one-entry skid register. When
//   angles stalls, the next finished result parks in the skid register and
//   points.ready drops only once that entry is full; the pipeline then holds.
//   Reset: arst_n clears all valid bits and both output entries; no
//   transaction is in flight afterwards and points.ready is high.
//   Equal points give degenerate = 1 with both angles 0.
module direction_to_spherical_angles #(
	parameter int COORD_WIDTH   = dtsa_pkg::COORD_WIDTH_DEF,
	parameter int CORDIC_STAGES = dtsa_pkg::CORDIC_STAGES_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	dtsa_points_if.sink   points,
	dtsa_angles_if.source angles
);
	import dtsa_pkg::*;

	localparam int AW  = COORD_WIDTH + 1;
	localparam int NSH = $clog2(AW);

	logic advance;
	logic out_v_q;
	logic skid_v_q;
	res_t out_q;
	res_t skid_q;

	// Whole pipeline moves together; it holds only while the skid entry is full.
	assign advance      = !skid_v_q;
	assign points.ready = advance;

	// ---------------------------------------------------------------- s1: differences
	logic                 v_s1;
	logic signed [AW-1:0] dx_s1;
	logic signed [AW-1:0] dy_s1;
	logic signed [AW-1:0] dz_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (advance) begin
			v_s1 <= points.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			dx_s1 <= {points.end_x[COORD_WIDTH-1], points.end_x}
				- {points.start_x[COORD_WIDTH-1], points.start_x};
			dy_s1 <= {points.end_y[COORD_WIDTH-1], points.end_y}
				- {points.start_y[COORD_WIDTH-1], points.start_y};
			dz_s1 <= {points.end_z[COORD_WIDTH-1], points.end_z}
				- {points.start_z[COORD_WIDTH-1], points.start_z};
		end
	end

	// ---------------------------------------------------------------- s2: magnitudes, signs
	logic          v_s2;
	logic [AW-1:0] ax_s2;
	logic [AW-1:0] ay_s2;
	logic [AW-1:0] az_s2;
	side_t         side_s2;
	side_t         side_c2;

	always_comb begin
		side_c2        = '0;
		side_c2.neg_dx = dx_s1[AW-1];
		side_c2.neg_dy = dy_s1[AW-1];
		side_c2.neg_dz = dz_s1[AW-1];
		side_c2.degen  = (dx_s1 == '0) && (dy_s1 == '0) && (dz_s1 == '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (advance) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			ax_s2   <= dx_s1[AW-1] ? $unsigned(-dx_s1) : $unsigned(dx_s1);
			ay_s2   <= dy_s1[AW-1] ? $unsigned(-dy_s1) : $unsigned(dy_s1);
			az_s2   <= dz_s1[AW-1] ? $unsigned(-dz_s1) : $unsigned(dz_s1);
			side_s2 <= side_c2;
		end
	end

	// ---------------------------------------------------------------- normalizing shifter
	// Left-justify the largest magnitude; halving shift per cell, largest first.
	logic          nv [NSH+1];
	logic [AW-1:0] nx [NSH+1];
	logic [AW-1:0] ny [NSH+1];
	logic [AW-1:0] nz [NSH+1];
	side_t         ns [NSH+1];

	assign nv[0] = v_s2;
	assign nx[0] = ax_s2;
	assign ny[0] = ay_s2;
	assign nz[0] = az_s2;
	assign ns[0] = side_s2;

	for (genvar g = 0; g < NSH; g++) begin : g_norm
		dtsa_norm_cell #(
			.AW (AW),
			.SH (1 << (NSH - 1 - g))
		) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.advance (advance),
			.valid   (nv[g]),
			.mag_x   (nx[g]),
			.mag_y   (ny[g]),
			.mag_z   (nz[g]),
			.side    (ns[g]),
			.valid_q (nv[g+1]),
			.mag_x_q (nx[g+1]),
			.mag_y_q (ny[g+1]),
			.mag_z_q (nz[g+1]),
			.side_q  (ns[g+1])
		);
	end

	// Take the top bits so the leading one lands at bit 32; lower bits drop, a narrower value is zero-padded.
	logic [NORM_W-1:0] x_nrm;
	logic [NORM_W-1:0] y_nrm;
	logic [NORM_W-1:0] z_nrm;

	if (AW >= NORM_W) begin : g_trunc
		assign x_nrm = nx[NSH][AW-1 -: NORM_W];
		assign y_nrm = ny[NSH][AW-1 -: NORM_W];
		assign z_nrm = nz[NSH][AW-1 -: NORM_W];
	end else begin : g_pad
		assign x_nrm = {nx[NSH], {(NORM_W-AW){1'b0}}};
		assign y_nrm = {ny[NSH], {(NORM_W-AW){1'b0}}};
		assign z_nrm = {nz[NSH], {(NORM_W-AW){1'b0}}};
	end

	// ---------------------------------------------------------------- s3: gain scaling of y
	logic [NORM_W+GAIN_W-1:0] y_prod;
	side_t                    side_c3;
	logic                     v_s3;
	logic [NORM_W-1:0]        x_s3;
	logic [NORM_W-1:0]        z_s3;
	side_t                    side_s3;

	assign y_prod = y_nrm * GAIN_Q28;

	always_comb begin
		side_c3        = ns[NSH];
		side_c3.zero_x = (x_nrm == '0);
		side_c3.zero_y = (y_nrm == '0);
		side_c3.zero_z = (z_nrm == '0);
		side_c3.x0     = x_nrm;
		side_c3.yk     = y_prod[NORM_W+GAIN_W-1:GAIN_FRAC];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (advance) begin
			v_s3 <= nv[NSH];
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			x_s3    <= x_nrm;
			z_s3    <= z_nrm;
			side_s3 <= side_c3;
		end
	end

	// ---------------------------------------------------------------- azimuth CORDIC chain
	logic  az_v    [CORDIC_STAGES+1];
	cw_t   az_x    [CORDIC_STAGES+1];
	cw_t   az_y    [CORDIC_STAGES+1];
	ang_t  az_a    [CORDIC_STAGES+1];
	side_t az_side [CORDIC_STAGES+1];

	assign az_v[0]    = v_s3;
	assign az_x[0]    = cw_t'(x_s3);
	assign az_y[0]    = cw_t'(z_s3);
	assign az_a[0]    = '0;
	assign az_side[0] = side_s3;

	for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_az
		dtsa_cordic_cell #(
			.STAGE (i)
		) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.advance (advance),
			.valid   (az_v[i]),
			.x       (az_x[i]),
			.y       (az_y[i]),
			.a       (az_a[i]),
			.side    (az_side[i]),
			.valid_q (az_v[i+1]),
			.x_q     (az_x[i+1]),
			.y_q     (az_y[i+1]),
			.a_q     (az_a[i+1]),
			.side_q  (az_side[i+1])
		);
	end

	// ---------------------------------------------------------------- s4: azimuth result
	side_t az_sd;
	qmag_t a_phi;
	qmag_t phi_m;
	cw_t   r_c4;
	side_t side_c4;
	logic  v_s4;
	cw_t   r_s4;
	cw_t   yk_s4;
	side_t side_s4;

	always_comb begin
		az_sd = az_side[CORDIC_STAGES];
		if (az_sd.zero_z) begin
			// no z part: angle 0, magnitude is x itself
			a_phi = '0;
			r_c4  = cw_t'(az_sd.x0);
		end else if (az_sd.zero_x) begin
			a_phi = DEG90_Q8;
			r_c4  = '0;
		end else begin
			a_phi = clamp_q8(az_a[CORDIC_STAGES]);
			r_c4  = az_x[CORDIC_STAGES];
		end
		phi_m       = az_sd.neg_dx ? (DEG180_Q8 - a_phi) : a_phi;
		side_c4     = az_sd;
		side_c4.phi = to_deg(phi_m, az_sd.neg_dz);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else if (advance) begin
			v_s4 <= az_v[CORDIC_STAGES];
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			r_s4    <= r_c4;
			yk_s4   <= cw_t'(az_sd.yk);
			side_s4 <= side_c4;
		end
	end

	// ---------------------------------------------------------------- elevation CORDIC chain
	logic  el_v    [CORDIC_STAGES+1];
	cw_t   el_x    [CORDIC_STAGES+1];
	cw_t   el_y    [CORDIC_STAGES+1];
	ang_t  el_a    [CORDIC_STAGES+1];
	side_t el_side [CORDIC_STAGES+1];

	assign el_v[0]    = v_s4;
	assign el_x[0]    = r_s4;
	assign el_y[0]    = yk_s4;
	assign el_a[0]    = '0;
	assign el_side[0] = side_s4;

	for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_el
		dtsa_cordic_cell #(
			.STAGE (i)
		) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.advance (advance),
			.valid   (el_v[i]),
			.x       (el_x[i]),
			.y       (el_y[i]),
			.a       (el_a[i]),
			.side    (el_side[i]),
			.valid_q (el_v[i+1]),
			.x_q     (el_x[i+1]),
			.y_q     (el_y[i+1]),
			.a_q     (el_a[i+1]),
			.side_q  (el_side[i+1])
		);
	end

	// ---------------------------------------------------------------- final angles
	side_t el_sd;
	qmag_t a_th;
	res_t  res_c;
	logic  res_push;

	always_comb begin
		el_sd = el_side[CORDIC_STAGES];
		if (el_sd.zero_y) begin
			a_th = '0;
		end else if (el_sd.zero_x && el_sd.zero_z) begin
			// straight up or down
			a_th = DEG90_Q8;
		end else begin
			a_th = clamp_q8(el_a[CORDIC_STAGES]);
		end
		if (el_sd.degen) begin
			res_c.theta = '0;
			res_c.phi   = '0;
			res_c.degen = 1'b1;
		end else begin
			res_c.theta = to_deg(a_th, el_sd.neg_dy);
			res_c.phi   = el_sd.phi;
			res_c.degen = 1'b0;
		end
	end

	// A finished transaction leaves the chain only on a cycle the pipeline moves.
	assign res_push = el_v[CORDIC_STAGES] && advance;

	// ---------------------------------------------------------------- output register and skid
	logic out_free;
	assign out_free = !out_v_q || angles.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q  <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (out_free) begin
			if (skid_v_q) begin
				out_v_q  <= 1'b1;
				skid_v_q <= 1'b0;
			end else begin
				out_v_q <= res_push;
			end
		end else if (res_push) begin
			skid_v_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free) begin
			out_q <= skid_v_q ? skid_q : res_c;
		end else if (res_push) begin
			skid_q <= res_c;
		end
	end

	assign angles.valid      = out_v_q;
	assign angles.theta_deg  = out_q.theta;
	assign angles.phi_deg    = out_q.phi;
	assign angles.degenerate = out_q.degen;

	// ---------------------------------------------------------------- checks
	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_v_q |-> out_v_q)
		else $error("skid entry full while output register empty");

	a_skid_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(skid_v_q) |-> $past(angles.valid && !angles.ready))
		else $error("skid entry filled without an output stall");

	a_degen_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(angles.valid && angles.degenerate) |->
			(angles.theta_deg == '0) && (angles.phi_deg == '0))
		else $error("degenerate result with nonzero angles");

	a_angle_range: assert property (@(posedge clk) disable iff (!arst_n)
		angles.valid |-> (angles.theta_deg < FULL_TURN) && (angles.phi_deg < FULL_TURN))
		else $error("angle outside 0..359");

endmodule

// File: test/tb_direction_to_spherical_angles.sv
// Testbench for direction_to_spherical_angles: point pairs go in, angle transactions come out.
// Holds its own angle predictor and checks each result in order; depends on dtsa_pkg,
// dtsa_points_if, dtsa_angles_if and the block itself.
module tb_direction_to_spherical_angles;
	timeunit 1ns;
	timeprecision 1ps;

	// Predictor constants, kept apart from the package on purpose.
	localparam int STAGES        = 20;
	localparam int Q8_RIGHT      = 23040;  // 90 degrees, 8 fraction bits
	localparam int Q8_STRAIGHT   = 46080;  // 180 degrees, 8 fraction bits
	localparam int TURN_DEG      = 360;
	localparam longint unsigned KGAIN_Q28 = 64'd442048841;
	localparam longint unsigned NORM_LO   = 64'h1_0000_0000;
	localparam longint unsigned NORM_HI   = 64'h2_0000_0000;
	localparam int ATAN_DEG_Q8 [32] = '{
		11520, 6801, 3593, 1824, 916, 458, 229, 115,
		57, 29, 14, 7, 4, 2, 1, 0,
		0, 0, 0, 0, 0, 0, 0, 0,
		0, 0, 0, 0, 0, 0, 0, 0
	};

	// Run control.
	localparam int PIPE_LATENCY = 51;
	localparam int IDLE_PCT     = 8;
	localparam int HOLD_CYCLES  = 400;
	localparam int CYCLE_LIMIT  = 300000;

	localparam logic [31:0] MAXC = 32'h7fff_ffff;
	localparam logic [31:0] MINC = 32'h8000_0000;

	typedef struct packed {
		logic [31:0] sx, sy, sz, ex, ey, ez;
	} points_t;

	logic clk;
	logic arst_n;

	dtsa_points_if points_ch ();
	dtsa_angles_if angles_ch ();

	direction_to_spherical_angles u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.points (points_ch),
		.angles (angles_ch)
	);

	// Angles still owed by the block, oldest first.
	dtsa_pkg::res_t angles_due [$];
	dtsa_pkg::res_t due_now;
	int             mismatches;
	int             cycles;

	// Idle switches and hold-off requests, written only by the test sequence; hold_seen and hold_left are the receiver's.
	bit src_idle_on;
	bit snk_idle_on;
	int hold_requests;
	int hold_seen;
	int hold_left;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// ------------------------------------------------------------------
	// Angle predictor
	// ------------------------------------------------------------------

	// Vectoring CORDIC on nonnegative (x, y); returns the clamped Q8 angle
	// and hands back the final x as the magnitude.
	function automatic int cordic_vector(input longint x0, input longint y0,
			output longint mag);
		longint x, y, xs, ys;
		int     acc;
		x = x0;
		y = y0;
		acc = 0;
		for (int i = 0; i < STAGES; i++) begin
			xs = x >>> i;
			ys = y >>> i;
			if (y >= 0) begin
				x = x + ys;
				y = y - xs;
				acc += ATAN_DEG_Q8[i];
			end else begin
				x = x - ys;
				y = y + xs;
				acc -= ATAN_DEG_Q8[i];
			end
		end
		mag = x;
		if (acc < 0)
			acc = 0;
		if (acc > Q8_RIGHT)
			acc = Q8_RIGHT;
		return acc;
	endfunction

	// Truncate a Q8 magnitude to whole degrees; wrap negatives by a full turn.
	function automatic dtsa_pkg::deg_t whole_deg(input int q8, input bit neg);
		dtsa_pkg::deg_t w;
		w = dtsa_pkg::deg_t'(q8 >> 8);
		if (neg && w != 0)
			return dtsa_pkg::deg_t'(TURN_DEG) - w;
		return w;
	endfunction

	function automatic dtsa_pkg::res_t predict_angles(input points_t p);
		longint          dx, dy, dz, mx, my, mz, rmag, spare;
		longint unsigned ax, ay, az, peak, yk;
		int              a_phi, a_th, phi_full;
		dtsa_pkg::res_t  r;
		dx = longint'($signed(p.ex)) - longint'($signed(p.sx));
		dy = longint'($signed(p.ey)) - longint'($signed(p.sy));
		dz = longint'($signed(p.ez)) - longint'($signed(p.sz));
		r.degen = 1'b0;
		if (dx == 0 && dy == 0 && dz == 0) begin
			r.theta = '0;
			r.phi   = '0;
			r.degen = 1'b1;
			return r;
		end
		ax = (dx < 0) ? -dx : dx;
		ay = (dy < 0) ? -dy : dy;
		az = (dz < 0) ? -dz : dz;
		peak = ax;
		if (ay > peak)
			peak = ay;
		if (az > peak)
			peak = az;
		// bring the largest magnitude into [2^32, 2^33)
		while (peak < NORM_LO) begin
			peak <<= 1;
			ax <<= 1;
			ay <<= 1;
			az <<= 1;
		end
		while (peak >= NORM_HI) begin
			peak >>= 1;
			ax >>= 1;
			ay >>= 1;
			az >>= 1;
		end
		mx = longint'(ax);
		my = longint'(ay);
		mz = longint'(az);

		if (mz == 0) begin
			a_phi = 0;
			rmag = mx;
		end else if (mx == 0) begin
			a_phi = Q8_RIGHT;
			rmag = 0;
		end else begin
			a_phi = cordic_vector(mx, mz, rmag);
		end
		phi_full = (dx < 0) ? Q8_STRAIGHT - a_phi : a_phi;

		if (my == 0) begin
			a_th = 0;
		end else if (mx == 0 && mz == 0) begin
			a_th = Q8_RIGHT;
		end else begin
			// match the CORDIC gain that the azimuth pass left on rmag
			yk = (ay * KGAIN_Q28) >> 28;
			a_th = cordic_vector(rmag, longint'(yk), spare);
		end

		r.theta = whole_deg(a_th, dy < 0);
		r.phi   = whole_deg(phi_full, dz < 0);
		return r;
	endfunction

	// ------------------------------------------------------------------
	// Stimulus helpers
	// ------------------------------------------------------------------

	// End point = start point + delta, wrapping at 32 bits like the ports do.
	function automatic points_t offset_points(input logic [31:0] sx, sy, sz,
			input int dx, dy, dz);
		points_t p;
		p.sx = sx;
		p.sy = sy;
		p.sz = sz;
		p.ex = 32'(sx + dx);
		p.ey = 32'(sy + dy);
		p.ez = 32'(sz + dz);
		return p;
	endfunction

	function automatic int small_delta(input int span);
		return int'($urandom_range(0, 2 * span)) - span;
	endfunction

	// One random pair of points, mixing full-range, near-equal, axis-aligned,
	// equal, mixed-scale and near-origin shapes.
	function automatic points_t random_points();
		points_t p;
		int      kind;
		int      big;
		p.sx = $urandom;
		p.sy = $urandom;
		p.sz = $urandom;
		p.ex = $urandom;
		p.ey = $urandom;
		p.ez = $urandom;
		kind = $urandom_range(0, 9);
		case (kind)
			4, 5: begin
				p = offset_points(p.sx, p.sy, p.sz,
					small_delta(1000), small_delta(1000), small_delta(1000));
			end
			6: begin
				p = offset_points(p.sx, p.sy, p.sz,
					$urandom_range(0, 1) ? 0 : int'($urandom),
					$urandom_range(0, 1) ? 0 : int'($urandom),
					$urandom_range(0, 1) ? 0 : int'($urandom));
			end
			7: begin
				p = offset_points(p.sx, p.sy, p.sz, 0, 0, 0);
			end
			8: begin
				big = int'($urandom);
				case ($urandom_range(0, 2))
					0:       p = offset_points(p.sx, p.sy, p.sz, big,
							small_delta(3), small_delta(3));
					1:       p = offset_points(p.sx, p.sy, p.sz, small_delta(3),
							big, small_delta(3));
					default: p = offset_points(p.sx, p.sy, p.sz, small_delta(3),
							small_delta(3), big);
				endcase
			end
			9: begin
				p.sx = 32'(small_delta(4));
				p.sy = 32'(small_delta(4));
				p.sz = 32'(small_delta(4));
				p.ex = 32'(small_delta(4));
				p.ey = 32'(small_delta(4));
				p.ez = 32'(small_delta(4));
			end
			default: ;
		endcase
		return p;
	endfunction

	// Offer one point pair, wait for its transaction, then record the angles
	// it must produce. Entered and left just after a falling edge.
	task automatic send_points(input points_t p);
		while (src_idle_on && $urandom_range(0, 99) < IDLE_PCT) begin
			points_ch.valid <= 1'b0;
			@(negedge clk);
		end
		points_ch.valid   <= 1'b1;
		points_ch.start_x <= p.sx;
		points_ch.start_y <= p.sy;
		points_ch.start_z <= p.sz;
		points_ch.end_x   <= p.ex;
		points_ch.end_y   <= p.ey;
		points_ch.end_z   <= p.ez;
		@(posedge clk);
		while (!points_ch.ready)
			@(posedge clk);
		angles_due = {angles_due, predict_angles(p)};
		@(negedge clk);
	endtask

	// Drop valid and hold the sender until every owed result has arrived.
	task automatic wait_all_results();
		points_ch.valid <= 1'b0;
		while (angles_due.size() != 0)
			@(negedge clk);
	endtask

	// ------------------------------------------------------------------
	// Test tasks
	// ------------------------------------------------------------------

	// Extremes, every axis and quadrant, and each corner case of the angle rules.
	task automatic test_directed();
		src_idle_on = 1'b0;
		snk_idle_on = 1'b0;
		// equal points: degenerate flag, both angles zero
		send_points(offset_points(32'd0, 32'd0, 32'd0, 0, 0, 0));
		send_points(offset_points(MAXC, MAXC, MAXC, 0, 0, 0));
		send_points(offset_points(MINC, MINC, MINC, 0, 0, 0));
		// axes: zero dz gives base 0, zero dx gives base 90, zero horizontal gives 90
		send_points(offset_points(32'd0, 32'd0, 32'd0, 65536, 0, 0));
		send_points(offset_points(32'd0, 32'd0, 32'd0, -65536, 0, 0));
		send_points(offset_points(32'd0, 32'd0, 32'd0, 0, 0, 65536));
		send_points(offset_points(32'd0, 32'd0, 32'd0, 0, 0, -65536));
		send_points(offset_points(32'd0, 32'd0, 32'd0, 0, 65536, 0));
		send_points(offset_points(32'd0, 32'd0, 32'd0, 0, -65536, 0));
		// full-scale differences in every direction
		send_points(points_t'{MINC, MINC, MINC, MAXC, MAXC, MAXC});
		send_points(points_t'{MAXC, MAXC, MAXC, MINC, MINC, MINC});
		send_points(points_t'{MINC, 32'd0, 32'd0, MAXC, 32'd0, 32'd0});
		send_points(points_t'{MAXC, MINC, 32'd0, MINC, MAXC, 32'd0});
		// small negatives that truncate to a negative zero
		send_points(offset_points(32'd0, 32'd0, 32'd0, 1 << 30, -1, 0));
		send_points(offset_points(32'd0, 32'd0, 32'd0, 1 << 30, 0, -1));
		// zero dx with the other two set, zero dy alone
		send_points(offset_points(32'd0, 32'd0, 32'd0, 0, 5, -7));
		send_points(offset_points(32'd0, 32'd0, 32'd0, 3, 0, 4));
		// diagonals and the remaining quadrants
		send_points(offset_points(32'd0, 32'd0, 32'd0, 1, 1, 1));
		send_points(offset_points(32'd0, 32'd0, 32'd0, -1, -1, -1));
		send_points(offset_points(32'd0, 32'd0, 32'd0, -3, 0, -4));
		send_points(offset_points(32'd0, 32'd0, 32'd0, 3, 0, -4));
		send_points(offset_points(32'd0, 32'd0, 32'd0, -3, 0, 4));
		send_points(offset_points(MAXC, 32'd0, MINC, 32'd1, 32'd0, 32'd0));
		// pause the sender until the block is empty
		wait_all_results();
	endtask

	// Random shapes with both sides idling now and then.
	task automatic test_random_mix(input int count);
		src_idle_on = 1'b1;
		snk_idle_on = 1'b1;
		repeat (count)
			send_points(random_points());
	endtask

	// Stall the receiver for a long stretch while items keep coming, so the
	// pipeline and skid entry fill and the input stalls; then drain.
	task automatic test_back_pressure(input int count);
		src_idle_on = 1'b0;
		snk_idle_on = 1'b1;
		hold_requests++;
		repeat (count)
			send_points(random_points());
		wait_all_results();
	endtask

	// Back-to-back transactions with no idling on either side.
	task automatic test_full_rate(input int count);
		src_idle_on = 1'b0;
		snk_idle_on = 1'b0;
		repeat (count)
			send_points(random_points());
	endtask

	// ------------------------------------------------------------------
	// Receiver: drop ready at random, or for a long hold when asked.
	// ------------------------------------------------------------------
	initial begin
		hold_seen = 0;
		hold_left = 0;
		angles_ch.ready <= 1'b0;
		forever begin
			@(negedge clk);
			if (hold_seen != hold_requests) begin
				hold_seen = hold_requests;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				angles_ch.ready <= 1'b0;
				hold_left--;
			end else if (snk_idle_on && $urandom_range(0, 99) < IDLE_PCT) begin
				angles_ch.ready <= 1'b0;
			end else begin
				angles_ch.ready <= 1'b1;
			end
		end
	end

	// ------------------------------------------------------------------
	// Result check: compare each angles transaction with the oldest expectation.
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		if (arst_n && angles_ch.valid && angles_ch.ready) begin
			if (angles_due.size() == 0) begin
				$error("unexpected angles: theta_deg %0d phi_deg %0d degenerate %0d",
					angles_ch.theta_deg, angles_ch.phi_deg, angles_ch.degenerate);
				mismatches++;
			end else begin
				due_now = angles_due.pop_front();
				if (angles_ch.theta_deg !== due_now.theta) begin
					$error("theta_deg: expected %0d, actual %0d",
						due_now.theta, angles_ch.theta_deg);
					mismatches++;
				end
				if (angles_ch.phi_deg !== due_now.phi) begin
					$error("phi_deg: expected %0d, actual %0d",
						due_now.phi, angles_ch.phi_deg);
					mismatches++;
				end
				if (angles_ch.degenerate !== due_now.degen) begin
					$error("degenerate: expected %0d, actual %0d",
						due_now.degen, angles_ch.degenerate);
					mismatches++;
				end
			end
		end
	end

	// Watchdog: end the run with a mismatch once the cycle limit is reached, as when the block stops answering.
	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// Test sequence
	// ------------------------------------------------------------------
	initial begin
		mismatches    = 0;
		cycles        = 0;
		src_idle_on   = 1'b0;
		snk_idle_on   = 1'b0;
		hold_requests = 0;
		// hold every input at a known value through reset
		arst_n = 1'b0;
		points_ch.valid   <= 1'b0;
		points_ch.start_x <= '0;
		points_ch.start_y <= '0;
		points_ch.start_z <= '0;
		points_ch.end_x   <= '0;
		points_ch.end_y   <= '0;
		points_ch.end_z   <= '0;
		repeat (6)
			@(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		test_directed();
		test_random_mix(1200);
		test_back_pressure(300);
		test_full_rate(330);

		// drain, then give stray transactions time to show up
		wait_all_results();
		repeat (PIPE_LATENCY + 20)
			@(negedge clk);
		if (mismatches == 0 && angles_due.size() == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
